@@ src/vbst_pkg.sv @@
// Shared types and constants for the valid-bit slot table.
// Holds the beat layouts, operation and status codes, FSM states and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package vbst_pkg;

   // Configuration register width.
   localparam int CSR_W = 6;

   // Request beat layout: tuser carries op, tdata the remaining fields.
   localparam int OP_W          = 2;
   localparam int SEL_W         = 5;
   localparam int EDATA_W       = 32;
   localparam int ESIZE_W       = 16;
   localparam int REQ_SEL_LSB   = 0;
   localparam int REQ_DATA_LSB  = REQ_SEL_LSB + SEL_W;
   localparam int REQ_SIZE_LSB  = REQ_DATA_LSB + EDATA_W;
   localparam int REQ_TDATA_W   = 56;

   // Response beat layout: tuser carries status, tdata the remaining fields.
   localparam int STATUS_W      = 2;
   localparam int CNT_FIELD_W   = 6;
   localparam int RSP_SLOT_LSB  = 0;
   localparam int RSP_DATA_LSB  = RSP_SLOT_LSB + SEL_W;
   localparam int RSP_SIZE_LSB  = RSP_DATA_LSB + EDATA_W;
   localparam int RSP_CNT_LSB   = RSP_SIZE_LSB + ESIZE_W;
   localparam int RSP_PAD_W     = 5;
   localparam int RSP_TDATA_W   = 64;

   // Largest count a response can report (the slot limit never exceeds 32).
   localparam int MAX_COUNT     = 32;

   // The scan walker examines this many slots per cycle.
   localparam int CHUNK         = 8;
   localparam int CHUNK_POS_W   = 3;
   localparam int CHUNK_CNT_W   = 4;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND = 2'd0,
      OP_REMOVE = 2'd1,
      OP_GET    = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_RANGE = 2'd2,
      STAT_EMPTY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;    // capture the request beat and arm the scan
      logic scan;    // examine one chunk of the slot vector
      logic finish;  // commit the operation and load the response register
   } vbst_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic need_scan;  // the incoming beat needs a walk over the slots
      logic found;      // the current chunk holds the wanted slot
      logic last;       // the current chunk is the final one
      logic out_free;   // the response register can take a new result
   } vbst_stat_type;

endpackage

`default_nettype wire

@@ src/valid_bit_slot_table.sv @@
// Valid-bit slot table: a table of SLOTS entries, each with a valid bit, a
// data word and a size word, plus a count of valid entries. Each request beat
// (append, remove or get) yields exactly one response beat. Remove and the
// unused op code skip the walk and go straight to the finish state. Append
// and get walk the valid-bit vector eight slots per cycle; the entry memory
// read overlaps the last step of the walk. A get whose rank is not below the
// count skips the walk too. A new request may be accepted while a finished
// response waits; that request's response waits for the earlier one to be
// taken. Valid bits clear in the reset cycle; no clearing pass is run.
// Depends on vbst_pkg, vbst_ctrl and vbst_datapath.
`default_nettype none

module valid_bit_slot_table
   import vbst_pkg::*;
#(
   parameter int SLOTS      = 32,
   parameter int DATA_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   // Configuration: slots_in_use.
   input  logic                   csr_wen,
   input  logic [CSR_W-1:0]       csr_wdata,
   // Request channel.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [OP_W-1:0]        req_tuser,  // op
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // slot_or_rank, entry_data, entry_size
   // Response channel.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [STATUS_W-1:0]    rsp_tuser,  // status
   output logic [RSP_TDATA_W-1:0] rsp_tdata   // slot, found_data, found_size, entry_count
);

   vbst_cmd_type  cmd;
   vbst_stat_type stat;

   vbst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   vbst_datapath #(
      .SLOTS      (SLOTS),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

`default_nettype wire

@@ src/vbst_ctrl.sv @@
// Controller state machine for the valid-bit slot table.
// Depends on vbst_pkg for the state type and the command/status structs.
`default_nettype none

module vbst_ctrl
   import vbst_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  vbst_stat_type stat,
   output vbst_cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = stat.need_scan ? S_SCAN : S_FINISH;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.found || stat.last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // Wait until the previous result has been taken.
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ src/vbst_datapath.sv @@
// Datapath of the valid-bit slot table: request capture, valid bits, entry
// count, chunked rank-select walker, data/size memories and response register.
// Depends on vbst_pkg for codes, beat layout and the command/status structs.
`default_nettype none

module vbst_datapath
   import vbst_pkg::*;
#(
   parameter int SLOTS      = 32,
   parameter int DATA_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wen,
   input  logic [CSR_W-1:0]       csr_wdata,
   input  logic [OP_W-1:0]        req_tuser,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [STATUS_W-1:0]    rsp_tuser,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  vbst_cmd_type           cmd,
   output vbst_stat_type          stat
);

   localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW   = $clog2(SLOTS + 1);
   localparam int LW   = (CW > CSR_W) ? CW : CSR_W;
   localparam int RW   = (CW > CHUNK_CNT_W) ? CW : CHUNK_CNT_W;
   localparam int NCH  = (SLOTS + CHUNK - 1) / CHUNK;
   localparam int CHW  = (NCH > 1) ? $clog2(NCH) : 1;
   localparam int PADW = NCH * CHUNK;

   // Configuration and slot limit.
   logic [CSR_W-1:0]      slots_in_use_ff;
   logic [CW-1:0]         lim;

   // Captured request.
   op_type                op_ff;
   logic [SEL_W-1:0]      sel_ff;
   logic [DATA_WIDTH-1:0] wdata_ff;
   logic [ESIZE_W-1:0]    wsize_ff;
   op_type                req_op;
   logic [SEL_W-1:0]      req_sel;

   // Table state.
   logic [SLOTS-1:0]      valid_ff;
   logic [CW-1:0]         cnt_ff;
   logic [DATA_WIDTH-1:0] data_mem [SLOTS];
   logic [ESIZE_W-1:0]    size_mem [SLOTS];
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic [ESIZE_W-1:0]    rd_size_ff;

   // Scan walker.
   logic [PADW-1:0]        vec_pad;
   logic [CHUNK-1:0]       chunk_bits;
   logic [CHUNK_CNT_W-1:0] chunk_pop;
   logic [CHUNK_CNT_W-1:0] seen_cnt;
   logic [CHUNK_POS_W-1:0] hit_pos;
   logic                   hit;
   logic [IW-1:0]          scan_slot;
   logic [CHW-1:0]         chunk_ff;
   logic [CW-1:0]          rem_ff;
   logic                   found_ff;
   logic [IW-1:0]          slot_ff;

   // Commit and result.
   logic [IW-1:0]         sel_idx;
   logic                  set_valid;
   logic                  clr_valid;
   logic [CW-1:0]         cnt_next;
   status_type            res_status;
   logic [SEL_W-1:0]      res_slot;
   logic [EDATA_W-1:0]    res_data;
   logic [ESIZE_W-1:0]    res_size;
   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   rsp_user_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   assign req_op  = op_type'(req_tuser);
   assign req_sel = req_tdata[REQ_SEL_LSB +: SEL_W];

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         slots_in_use_ff <= CSR_W'(MAX_COUNT);
      end else if (csr_wen) begin
         slots_in_use_ff <= csr_wdata;
      end
   end

   // The limit saturates at the table size.
   always_comb begin
      if (LW'(slots_in_use_ff) > LW'(SLOTS)) begin
         lim = CW'(SLOTS);
      end else begin
         lim = CW'(slots_in_use_ff);
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_op;
         sel_ff   <= req_sel;
         wdata_ff <= DATA_WIDTH'(req_tdata[REQ_DATA_LSB +: EDATA_W]);
         wsize_ff <= req_tdata[REQ_SIZE_LSB +: ESIZE_W];
      end
   end

   // Append searches free slots below the limit, get searches valid slots.
   always_comb begin
      vec_pad = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (op_ff == OP_APPEND) begin
            vec_pad[i] = !valid_ff[i] && (CW'(i) < lim);
         end else begin
            vec_pad[i] = valid_ff[i];
         end
      end
   end

   // One chunk per cycle: count its set bits and locate the wanted one.
   assign chunk_bits = vec_pad[{chunk_ff, {CHUNK_POS_W{1'b0}}} +: CHUNK];
   assign chunk_pop  = CHUNK_CNT_W'($countones(chunk_bits));

   always_comb begin
      seen_cnt = '0;
      hit_pos  = '0;
      hit      = 1'b0;
      for (int i = 0; i < CHUNK; i++) begin
         if (chunk_bits[i]) begin
            if (!hit && (RW'(seen_cnt) == RW'(rem_ff))) begin
               hit     = 1'b1;
               hit_pos = CHUNK_POS_W'(i);
            end
            seen_cnt = seen_cnt + 1'b1;
         end
      end
   end

   assign scan_slot = IW'({chunk_ff, hit_pos});

   // Walker registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         chunk_ff <= '0;
      end else if (cmd.load) begin
         found_ff <= 1'b0;
         chunk_ff <= '0;
         rem_ff   <= (req_op == OP_GET) ? CW'(req_sel) : '0;
      end else if (cmd.scan) begin
         if (hit) begin
            found_ff <= 1'b1;
            slot_ff  <= scan_slot;
         end else begin
            rem_ff   <= CW'(RW'(rem_ff) - RW'(chunk_pop));
            chunk_ff <= chunk_ff + 1'b1;
         end
      end
   end

   // Entry memories: read during the scan, written when an append commits.
   always_ff @(posedge clock) begin
      if (cmd.scan) begin
         rd_data_ff <= data_mem[scan_slot];
         rd_size_ff <= size_mem[scan_slot];
      end
      if (cmd.finish && set_valid) begin
         data_mem[slot_ff] <= wdata_ff;
         size_mem[slot_ff] <= wsize_ff;
      end
   end

   // Outcome of the captured operation.
   assign sel_idx = IW'(sel_ff);

   always_comb begin
      res_status = STAT_RANGE;
      res_slot   = '0;
      res_data   = '0;
      res_size   = '0;
      set_valid  = 1'b0;
      clr_valid  = 1'b0;
      case (op_ff)
         OP_APPEND: begin
            if (found_ff) begin
               res_status = STAT_OK;
               res_slot   = SEL_W'(slot_ff);
               set_valid  = 1'b1;
            end else begin
               res_status = STAT_FULL;
            end
         end
         OP_REMOVE: begin
            res_slot = sel_ff;
            if (LW'(sel_ff) >= LW'(lim)) begin
               res_status = STAT_RANGE;
            end else if (!valid_ff[sel_idx]) begin
               res_status = STAT_EMPTY;
            end else begin
               res_status = STAT_OK;
               clr_valid  = 1'b1;
            end
         end
         OP_GET: begin
            if (found_ff) begin
               res_status = STAT_OK;
               res_slot   = SEL_W'(slot_ff);
               res_data   = EDATA_W'(rd_data_ff);
               res_size   = rd_size_ff;
            end
         end
         default: begin
            res_status = STAT_RANGE;
         end
      endcase
   end

   always_comb begin
      cnt_next = cnt_ff;
      if (set_valid) begin
         cnt_next = cnt_ff + 1'b1;
      end else if (clr_valid) begin
         cnt_next = cnt_ff - 1'b1;
      end
   end

   // Valid bits and entry count.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         cnt_ff   <= '0;
      end else if (cmd.finish) begin
         if (set_valid) begin
            valid_ff[slot_ff] <= 1'b1;
         end
         if (clr_valid) begin
            valid_ff[sel_idx] <= 1'b0;
         end
         cnt_ff <= cnt_next;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_user_ff <= res_status;
         rsp_data_ff <= {{RSP_PAD_W{1'b0}}, CNT_FIELD_W'(cnt_next), res_size, res_data,
                         res_slot};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Status toward the controller.
   assign stat.need_scan = (req_op == OP_APPEND) ||
                           ((req_op == OP_GET) && (LW'(req_sel) < LW'(cnt_ff)));
   assign stat.found     = hit;
   assign stat.last      = (chunk_ff == CHW'(NCH - 1));
   assign stat.out_free  = !rsp_valid_ff || rsp_tready;

endmodule

`default_nettype wire

@@ src/vbst_checker.sv @@
// Port-level checker for the valid-bit slot table, bound to the top level.
// Depends on vbst_pkg for the beat layout and status codes.
`default_nettype none

module vbst_checker
   import vbst_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [STATUS_W-1:0]    rsp_tuser,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // A stalled response beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response beat changed while stalled");

   // Reset leaves no response pending.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // One request at a time: the port closes after each accepted beat.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while the previous one is in progress");

   // The count never exceeds the largest slot limit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_CNT_LSB +: CNT_FIELD_W] <= CNT_FIELD_W'(MAX_COUNT))
      else $error("entry count out of range");

   // Only a successful get returns entry contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != STAT_OK) |->
         rsp_tdata[RSP_DATA_LSB +: EDATA_W] == '0 && rsp_tdata[RSP_SIZE_LSB +: ESIZE_W] == '0)
      else $error("entry contents on a failed operation");

endmodule

bind valid_bit_slot_table vbst_checker u_vbst_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

@@ tb/sv/tb_valid_bit_slot_table.sv @@
// Self-checking testbench for the valid-bit slot table: a directed set of
// table operations, then random phases under several slot limits.
// Depends on vbst_pkg and valid_bit_slot_table.
`timescale 1ns / 100ps

module tb_valid_bit_slot_table;
   import vbst_pkg::*;

   localparam int SLOTS          = 32;
   localparam int DATA_WIDTH     = 32;
   localparam int SETTLE_CYCLES  = 8;    // outlasts the longest walk
   localparam int WATCHDOG_LIMIT = 500;  // quiet cycles before the run is abandoned
   localparam int PRINT_CAP      = 40;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct {
      status_type          status;
      logic [SEL_W-1:0]    slot;
      logic [EDATA_W-1:0]  data;
      logic [ESIZE_W-1:0]  size;
      logic [CNT_FIELD_W-1:0] count;
   } table_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wen = 1'b0;
   logic [CSR_W-1:0]       csr_wdata = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [OP_W-1:0]        req_tuser = '0;   // op
   logic [REQ_TDATA_W-1:0] req_tdata = '0;   // slot_or_rank, entry_data, entry_size
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [STATUS_W-1:0]    rsp_tuser;        // status
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // slot, found_data, found_size, entry_count

   // Shadow copy of the table.
   bit                  tbl_valid [SLOTS];
   logic [EDATA_W-1:0]  tbl_data [SLOTS];
   logic [ESIZE_W-1:0]  tbl_size [SLOTS];
   int                  tbl_count = 0;
   logic [CSR_W-1:0]    tbl_limit_reg = 6'd32;

   table_result_type expected_results [$];
   int error_count   = 0;
   int beats_sent    = 0;
   int results_taken = 0;
   int status_seen [4] = '{0, 0, 0, 0};
   int burst_left    = 0;

   valid_bit_slot_table #(
      .SLOTS      (SLOTS),
      .DATA_WIDTH (DATA_WIDTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Apply one operation to the shadow table and return the response it owes.
   function automatic table_result_type apply_table_op(input logic [OP_W-1:0] op,
                                                       input logic [SEL_W-1:0] sel,
                                                       input logic [EDATA_W-1:0] d,
                                                       input logic [ESIZE_W-1:0] s);
      table_result_type r;
      int lim;
      int seen;
      bit done;
      r.status = STAT_RANGE;
      r.slot   = '0;
      r.data   = '0;
      r.size   = '0;
      lim  = (tbl_limit_reg > SLOTS) ? SLOTS : int'(tbl_limit_reg);
      seen = 0;
      done = 1'b0;
      case (op)
         OP_APPEND: begin
            r.status = STAT_FULL;
            for (int i = 0; i < lim; i++) begin
               if (!done && !tbl_valid[i]) begin
                  tbl_valid[i] = 1'b1;
                  tbl_data[i]  = d;
                  tbl_size[i]  = s;
                  tbl_count++;
                  r.status = STAT_OK;
                  r.slot   = i[SEL_W-1:0];
                  done     = 1'b1;
               end
            end
         end
         OP_REMOVE: begin
            r.slot = sel;
            if (int'(sel) >= lim) begin
               r.status = STAT_RANGE;
            end else if (!tbl_valid[sel]) begin
               r.status = STAT_EMPTY;
            end else begin
               tbl_valid[sel] = 1'b0;
               tbl_count--;
               r.status = STAT_OK;
            end
         end
         OP_GET: begin
            // The rank walk covers every slot, including any above the limit.
            if (int'(sel) < tbl_count) begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (!done && tbl_valid[i]) begin
                     if (seen == int'(sel)) begin
                        r.status = STAT_OK;
                        r.slot   = i[SEL_W-1:0];
                        r.data   = tbl_data[i];
                        r.size   = tbl_size[i];
                        done     = 1'b1;
                     end
                     seen++;
                  end
               end
            end
         end
         default: ;
      endcase
      r.count = tbl_count[CNT_FIELD_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      error_count++;
      if (error_count <= PRINT_CAP)
         $display("%0t: mismatch in %s: expected %0h, got %0h", $realtime, what, want, got);
   endtask

   // Send one request beat, with a random gap between bursts, and record its
   // expected response when the beat is accepted.
   task automatic send_beat(input logic [OP_W-1:0] op, input logic [SEL_W-1:0] sel,
                            input logic [EDATA_W-1:0] d, input logic [ESIZE_W-1:0] s);
      logic [REQ_TDATA_W-1:0] beat;
      int gap;
      beat = '0;
      beat[REQ_SEL_LSB +: SEL_W]    = sel;
      beat[REQ_DATA_LSB +: EDATA_W] = d;
      beat[REQ_SIZE_LSB +: ESIZE_W] = s;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= beat;
      do @(posedge clock); while (!req_tready);
      expected_results.push_back(apply_table_op(op, sel, d, s));
      beats_sent++;
      burst_left--;
   endtask

   // Stop sending and wait for every response, then for the walker to settle.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_slot_limit(input logic [CSR_W-1:0] value);
      wait_idle();
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      tbl_limit_reg = value;
   endtask

   // One random operation; removes and gets mostly aim at live entries.
   task automatic send_random_op(input int append_pct);
      int pick;
      int live [$];
      logic [OP_W-1:0]    op;
      logic [SEL_W-1:0]   sel;
      pick = $urandom_range(0, 99);
      sel  = SEL_W'($urandom_range(0, SLOTS - 1));
      for (int i = 0; i < SLOTS; i++)
         if (tbl_valid[i]) live.push_back(i);
      if (pick < 3) begin
         op = OP_UNUSED;
      end else if (pick < append_pct) begin
         op = OP_APPEND;
      end else if (pick < append_pct + (100 - append_pct) / 2) begin
         op = OP_REMOVE;
         if (live.size() != 0 && $urandom_range(0, 9) < 7)
            sel = SEL_W'(live[$urandom_range(0, live.size() - 1)]);
      end else begin
         op = OP_GET;
         if (tbl_count > 0 && $urandom_range(0, 9) < 8)
            sel = SEL_W'($urandom_range(0, tbl_count - 1));
      end
      send_beat(op, sel, $urandom, ESIZE_W'($urandom_range(0, 16'hffff)));
   endtask

   // Empty table right after reset, and the unused op code.
   task automatic test_reset_state();
      send_beat(OP_GET, 5'd0, '0, '0);
      send_beat(OP_REMOVE, 5'd0, '0, '0);
      send_beat(OP_UNUSED, 5'd31, '1, '1);
      send_beat(OP_REMOVE, 5'd31, '0, '0);
   endtask

   // Appends with extreme contents, rank lookups, and reuse of a freed slot.
   task automatic test_append_get();
      send_beat(OP_APPEND, 5'd0, 32'h0, 16'h0);
      send_beat(OP_APPEND, 5'd31, 32'hffff_ffff, 16'hffff);
      send_beat(OP_APPEND, 5'd7, $urandom, ESIZE_W'($urandom_range(0, 16'hffff)));
      send_beat(OP_GET, 5'd0, '0, '0);
      send_beat(OP_GET, 5'd1, '0, '0);
      send_beat(OP_GET, 5'd2, '0, '0);
      send_beat(OP_GET, 5'd3, '0, '0);
      send_beat(OP_GET, 5'd31, '0, '0);
      send_beat(OP_REMOVE, 5'd1, '0, '0);
      send_beat(OP_APPEND, 5'd0, $urandom, ESIZE_W'($urandom_range(0, 16'hffff)));
   endtask

   // Limit of zero, a limit below live entries, and a saturated limit.
   task automatic test_limit_edges();
      write_slot_limit(6'd0);
      send_beat(OP_APPEND, 5'd0, $urandom, ESIZE_W'($urandom_range(0, 16'hffff)));
      send_beat(OP_REMOVE, 5'd0, '0, '0);
      send_beat(OP_GET, 5'd0, '0, '0);
      write_slot_limit(6'd2);
      send_beat(OP_APPEND, 5'd0, $urandom, ESIZE_W'($urandom_range(0, 16'hffff)));
      send_beat(OP_REMOVE, 5'd2, '0, '0);
      send_beat(OP_GET, 5'd2, '0, '0);
      write_slot_limit(6'd63);
      send_beat(OP_APPEND, 5'd0, $urandom, ESIZE_W'($urandom_range(0, 16'hffff)));
      send_beat(OP_REMOVE, 5'd31, '0, '0);
      send_beat(OP_GET, 5'd3, '0, '0);
   endtask

   task automatic test_random_phase(input logic [CSR_W-1:0] limit, input int append_pct,
                                    input int n_items);
      write_slot_limit(limit);
      repeat (n_items) send_random_op(append_pct);
   endtask

   // Receiver: runs of steady accept, random accept and hard stall.
   initial begin
      int mode;
      int mode_left;
      mode = 0;
      mode_left = 0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            mode = $urandom_range(0, 2);
            mode_left = (mode == 2) ? $urandom_range(1, 20) : $urandom_range(5, 60);
         end
         mode_left--;
         case (mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= 1'b0;
         endcase
      end
   end

   // Compare each response beat with the oldest expectation.
   always @(posedge clock) begin
      table_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_taken++;
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected response", 64'h0, {rsp_tuser, rsp_tdata[61:0]});
         end else begin
            want = expected_results.pop_front();
            status_seen[rsp_tuser]++;
            if (rsp_tuser !== want.status)
               report_mismatch("status", 64'(want.status), 64'(rsp_tuser));
            if (rsp_tdata[RSP_SLOT_LSB +: SEL_W] !== want.slot)
               report_mismatch("slot", 64'(want.slot),
                               64'(rsp_tdata[RSP_SLOT_LSB +: SEL_W]));
            if (rsp_tdata[RSP_DATA_LSB +: EDATA_W] !== want.data)
               report_mismatch("found_data", 64'(want.data),
                               64'(rsp_tdata[RSP_DATA_LSB +: EDATA_W]));
            if (rsp_tdata[RSP_SIZE_LSB +: ESIZE_W] !== want.size)
               report_mismatch("found_size", 64'(want.size),
                               64'(rsp_tdata[RSP_SIZE_LSB +: ESIZE_W]));
            if (rsp_tdata[RSP_CNT_LSB +: CNT_FIELD_W] !== want.count)
               report_mismatch("entry_count", 64'(want.count),
                               64'(rsp_tdata[RSP_CNT_LSB +: CNT_FIELD_W]));
         end
      end
   end

   // Watchdog: give up after a long stretch with no beat on either channel.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no handshake for %0d cycles", $realtime, WATCHDOG_LIMIT);
      $display("[valid_bit_slot_table] ERROR");
      $finish;
   end

   initial begin
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_append_get();
      test_limit_edges();
      // Heavy appends first so the full table is reached under the top limit.
      test_random_phase(6'd32, 75, 140);
      test_random_phase(6'd32, 40, 140);
      test_random_phase(6'd1, 50, 140);
      test_random_phase(6'd63, 60, 140);
      test_random_phase(6'd0, 50, 140);
      test_random_phase(6'd5, 55, 140);
      test_random_phase(6'd17, 45, 140);
      test_random_phase(6'd2, 50, 140);
      test_random_phase(6'd40, 70, 140);
      test_random_phase(6'd32, 30, 140);
      test_random_phase(CSR_W'($urandom_range(0, 63)), 50, 140);
      wait_idle();

      $display("Sent %0d request beats over eleven slot limits, %0d responses checked.",
               beats_sent, results_taken);
      $display("Responses by status: ok %0d, full %0d, out of range %0d, empty %0d.",
               status_seen[STAT_OK], status_seen[STAT_FULL], status_seen[STAT_RANGE],
               status_seen[STAT_EMPTY]);
      if (error_count == 0 && expected_results.size() == 0)
         $display("[valid_bit_slot_table] OK");
      else
         $display("[valid_bit_slot_table] ERROR");
      $finish;
   end

endmodule
